@@ sv/bdch_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdch_pkg: shared types and constants
// Register indexes, reset values and the structs passed between modules of
// the button debounce, click and hold block.
// ----------------------------------------------------------------------------
package bdch_pkg;

   localparam int unsigned TIME_WIDTH  = 32;
   localparam int unsigned CFG_WIDTH   = 15;
   localparam int unsigned INDEX_WIDTH = 2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 15'd20;
   localparam logic [CFG_WIDTH-1:0] DOUBLE_GAP_RESET = 15'd500;
   localparam logic [CFG_WIDTH-1:0] HOLD_RESET       = 15'd1000;

   typedef enum logic [INDEX_WIDTH-1:0] {
      CSR_DEBOUNCE   = 2'd0,
      CSR_DOUBLE_GAP = 2'd1,
      CSR_HOLD       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_WIDTH-1:0] debounce_ms;
      logic [CFG_WIDTH-1:0] double_gap_ms;
      logic [CFG_WIDTH-1:0] hold_ms;
   } cfg_type;

   typedef struct packed {
      logic held_edge;
      logic held;
      logic double_clicked;
      logic clicked_edge;
      logic pressed;
   } result_type;

endpackage
`default_nettype wire

@@ sv/bdch_cfg_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdch_cfg_regs: configuration registers
// Holds the debounce, double-click gap and hold times. Writes to an index
// beyond the register list are dropped.
// ----------------------------------------------------------------------------
module bdch_cfg_regs (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               wr_en,
   input  wire logic [bdch_pkg::INDEX_WIDTH-1:0]   wr_index,
   input  wire logic [bdch_pkg::CFG_WIDTH-1:0]     wr_data,
   output bdch_pkg::cfg_type                       cfg
);

   bdch_pkg::cfg_type cfg_ff;
   bdch_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (bdch_pkg::csr_index_type'(wr_index))
            bdch_pkg::CSR_DEBOUNCE:   cfg_in.debounce_ms   = wr_data;
            bdch_pkg::CSR_DOUBLE_GAP: cfg_in.double_gap_ms = wr_data;
            bdch_pkg::CSR_HOLD:       cfg_in.hold_ms       = wr_data;
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms   <= bdch_pkg::DEBOUNCE_RESET;
         cfg_ff.double_gap_ms <= bdch_pkg::DOUBLE_GAP_RESET;
         cfg_ff.hold_ms       <= bdch_pkg::HOLD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ sv/bdch_track.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bdch_track: button state tracker
// Keeps the debounce, click and hold state and computes the result of one
// poll. State advances only when a poll is accepted.
// ----------------------------------------------------------------------------
module bdch_track (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                accept,
   input  wire logic                                pin_level,
   input  wire logic [bdch_pkg::TIME_WIDTH-1:0]     now_ms,
   input  wire bdch_pkg::cfg_type                   cfg,
   output bdch_pkg::result_type                     result
);

   localparam int unsigned PadWidth = bdch_pkg::TIME_WIDTH - bdch_pkg::CFG_WIDTH;

   logic [bdch_pkg::TIME_WIDTH-1:0] last_low_time_ff, last_low_time_in;
   logic [bdch_pkg::TIME_WIDTH-1:0] first_click_time_ff, first_click_time_in;
   logic [bdch_pkg::TIME_WIDTH-1:0] hold_start_time_ff, hold_start_time_in;
   logic                            debounced_ff, debounced_in;
   logic                            pending_ff, pending_in;
   logic                            double_ff, double_in;
   logic                            held_ff, held_in;

   logic [bdch_pkg::TIME_WIDTH-1:0] low_age;
   logic [bdch_pkg::TIME_WIDTH-1:0] click_age;
   logic [bdch_pkg::TIME_WIDTH-1:0] hold_age;
   logic                            click_pulse;
   logic                            pending_mid;
   logic [bdch_pkg::TIME_WIDTH-1:0] first_click_mid;

   // Ages wrap with the time stamp, so plain modular subtraction is right.
   assign low_age   = now_ms - last_low_time_ff;
   assign click_age = now_ms - first_click_mid;
   assign hold_age  = now_ms - hold_start_time_ff;

   always_comb begin
      // Debounce: a low pin restarts the window.
      if (pin_level) begin
         debounced_in     = (low_age >= {{PadWidth{1'b0}}, cfg.debounce_ms});
         last_low_time_in = last_low_time_ff;
      end else begin
         debounced_in     = 1'b0;
         last_low_time_in = now_ms;
      end

      click_pulse = debounced_in & ~debounced_ff;

      // Double click: the first click arms, a second one fires.
      pending_mid     = pending_ff;
      first_click_mid = first_click_time_ff;
      double_in       = double_ff;
      if (click_pulse && !pending_ff) begin
         pending_mid     = 1'b1;
         first_click_mid = now_ms;
      end else if (click_pulse) begin
         double_in   = 1'b1;
         pending_mid = 1'b0;
      end else begin
         double_in = 1'b0;
      end

      // Expire a pending first click once the gap has passed.
      if (pending_mid && (click_age > {{PadWidth{1'b0}}, cfg.double_gap_ms})) begin
         pending_in          = 1'b0;
         first_click_time_in = '0;
      end else begin
         pending_in          = pending_mid;
         first_click_time_in = first_click_mid;
      end

      // Hold timer runs from the last poll that was not pressed.
      if (debounced_in) begin
         held_in            = (hold_age > {{PadWidth{1'b0}}, cfg.hold_ms});
         hold_start_time_in = hold_start_time_ff;
      end else begin
         held_in            = 1'b0;
         hold_start_time_in = now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_low_time_ff    <= '0;
         first_click_time_ff <= '0;
         hold_start_time_ff  <= '0;
         debounced_ff        <= 1'b0;
         pending_ff          <= 1'b0;
         double_ff           <= 1'b0;
         held_ff             <= 1'b0;
      end else if (accept) begin
         last_low_time_ff    <= last_low_time_in;
         first_click_time_ff <= first_click_time_in;
         hold_start_time_ff  <= hold_start_time_in;
         debounced_ff        <= debounced_in;
         pending_ff          <= pending_in;
         double_ff           <= double_in;
         held_ff             <= held_in;
      end
   end

   assign result.pressed        = debounced_in;
   assign result.clicked_edge   = click_pulse;
   assign result.double_clicked = double_in;
   assign result.held           = held_in;
   assign result.held_edge      = held_in & ~held_ff;

endmodule
`default_nettype wire

@@ sv/button_debounce_click_hold.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_click_hold: button debouncer with click, double-click and hold
// Takes one poll per beat (pin level and millisecond time stamp) and returns
// the debounced state with click, double-click and long-press flags.
// ----------------------------------------------------------------------------
// Output: each result beat is registered, in the cycle after its poll is accepted.
// Throughput: one poll per cycle; the tracker state and the result register
// update in the same cycle, so the only stall is a full, undrained result register.
// Reset: synchronous, active high; clears all tracker state and loads the
// timing registers with 20, 500 and 1000 ms. No clearing pass is needed.
// ----------------------------------------------------------------------------
module button_debounce_click_hold (
   input  wire logic         clock,
   input  wire logic         reset,

   // Poll channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,   // [0] pin_level, [32:1] now_ms, rest zero

   // Result channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [7:0]        rsp_tdata,   // [0] pressed, [1] clicked_edge,
                                          // [2] double_clicked, [3] held,
                                          // [4] held_edge, rest zero

   // Configuration write channel.
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [14:0]  csr_data
);

   logic                                     req_accept;
   logic                                     pin_level;
   logic [bdch_pkg::TIME_WIDTH-1:0]          now_ms;
   bdch_pkg::cfg_type                        cfg;
   bdch_pkg::result_type                     result;

   logic                                     rsp_valid_ff, rsp_valid_in;
   bdch_pkg::result_type                     rsp_data_ff;

   // Configuration writes are registered and are never refused.
   assign csr_ready = 1'b1;

   bdch_cfg_regs u_cfg_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // Unpack the poll beat.
   assign pin_level = req_tdata[0];
   assign now_ms    = req_tdata[32:1];

   // A new poll is taken whenever the result register is empty or is being
   // drained this cycle, so a waiting result never stalls the input side
   // more than necessary.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // The tracker computes the whole result in this cycle from the poll and
   // its stored state, and advances that state on acceptance.
   bdch_track u_track (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .pin_level (pin_level),
      .now_ms    (now_ms),
      .cfg       (cfg),
      .result    (result)
   );

   // Result register: loads on every accepted poll and empties once the
   // downstream side takes the beat.
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_data_ff.held_edge,
                        rsp_data_ff.held,
                        rsp_data_ff.double_clicked,
                        rsp_data_ff.clicked_edge,
                        rsp_data_ff.pressed};

   // Every accepted poll must show up as a result beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted poll did not produce a result beat");

   // A click edge can only be reported while the button reads as pressed.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> rsp_tdata[0])
      else $error("click edge without pressed");

   // Held implies pressed, and a held edge implies held.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[3] || rsp_tdata[4])) |-> (rsp_tdata[0] && rsp_tdata[3]))
      else $error("held flags inconsistent with pressed");

   // A double click needs a fresh click on the same poll.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[2]) |-> rsp_tdata[1])
      else $error("double click without click edge");

endmodule
`default_nettype wire

@@ test/button_debounce_click_hold_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// button_debounce_click_hold_test: self-checking bench for the button block
// Feeds polls of pin level and time stamp through the poll channel, predicts
// the press, click, double-click and hold flags of every poll, and compares
// each result beat with the prediction. Runs several timing settings and
// several idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module button_debounce_click_hold_test;

   localparam int unsigned TIME_BITS = bdch_pkg::TIME_WIDTH;
   // The index one past the last timing register; writes to it are dropped.
   localparam logic [bdch_pkg::INDEX_WIDTH-1:0] CSR_SPARE = 2'd3;
   localparam int unsigned CYCLE_LIMIT     = 400000;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   // The result appears in the cycle after its poll; this pause covers it.
   localparam int unsigned DRAIN_CYCLES    = 4;

   // One poll as it travels in req_tdata, the pin level in bit 0.
   typedef struct packed {
      logic [TIME_BITS-1:0] now_ms;
      logic                 pin_level;
   } poll_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = bdch_pkg::CSR_DEBOUNCE;
   logic [14:0] csr_data   = '0;

   button_debounce_click_hold i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Polls waiting to be offered, and flag sets waiting to come back.
   poll_type             poll_queue[$];
   bdch_pkg::result_type expected_flags[$];
   poll_type             offered_poll;
   int unsigned polls_queued = 0;
   int unsigned results_seen = 0;
   int unsigned fail_count   = 0;
   int unsigned cycle_count  = 0;

   // Idle rates in percent, set per phase by the stimulus process.
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;

   // Long receiver hold-off, requested by the stimulus and counted below.
   logic        hold_off_request = 1'b0;
   int unsigned hold_off_left    = 0;

   // Time stamp of the most recently queued poll.
   logic [TIME_BITS-1:0] stamp_ms = '0;

   // Our own copy of the timing registers and of the tracker state.
   bdch_pkg::cfg_type timing_cfg = '{debounce_ms: bdch_pkg::DEBOUNCE_RESET,
                                     double_gap_ms: bdch_pkg::DOUBLE_GAP_RESET,
                                     hold_ms: bdch_pkg::HOLD_RESET};
   logic [TIME_BITS-1:0] low_stamp      = '0;
   logic [TIME_BITS-1:0] first_stamp    = '0;
   logic [TIME_BITS-1:0] hold_stamp     = '0;
   logic                 is_pressed     = 1'b0;
   logic                 pressed_level  = 1'b0;
   logic                 first_pending  = 1'b0;
   logic                 double_flag    = 1'b0;
   logic                 is_held        = 1'b0;
   logic                 held_level     = 1'b0;

   // Advances the button tracker by one poll and returns the flags it shows.
   // The stages run in order, each one seeing what the previous ones just set.
   function automatic bdch_pkg::result_type track_button(input poll_type poll);
      bdch_pkg::result_type flags;
      logic [TIME_BITS-1:0] age;
      logic                 click;
      logic                 held_rise;

      // Debounce: the pin must have been high long enough since it was low.
      age = poll.now_ms - low_stamp;
      if (poll.pin_level) begin
         is_pressed = age >= TIME_BITS'(timing_cfg.debounce_ms);
      end else begin
         is_pressed = 1'b0;
         low_stamp  = poll.now_ms;
      end

      click         = is_pressed && !pressed_level;
      pressed_level = is_pressed;

      // A click either opens a pending first click or completes a double.
      // Opening one leaves the double flag as it was on this poll.
      if (click && !first_pending) begin
         first_pending = 1'b1;
         first_stamp   = poll.now_ms;
      end else if (click) begin
         double_flag   = 1'b1;
         first_pending = 1'b0;
      end else begin
         double_flag = 1'b0;
      end

      // A pending click that is too old is dropped, even the one just opened.
      age = poll.now_ms - first_stamp;
      if (first_pending && age > TIME_BITS'(timing_cfg.double_gap_ms)) begin
         first_pending = 1'b0;
         first_stamp   = '0;
      end

      // Hold: measured from the last poll on which the button was released.
      age = poll.now_ms - hold_stamp;
      if (is_pressed) begin
         is_held = age > TIME_BITS'(timing_cfg.hold_ms);
      end else begin
         hold_stamp = poll.now_ms;
         is_held    = 1'b0;
      end

      held_rise  = is_held && !held_level;
      held_level = is_held;

      flags.pressed        = is_pressed;
      flags.clicked_edge   = click;
      flags.double_clicked = double_flag;
      flags.held           = is_held;
      flags.held_edge      = held_rise;
      return flags;
   endfunction

   task automatic check_flag(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         fail_count++;
      end
   endtask

   // Poll driver. A beat on offer stays until it is taken; the flags it
   // should produce are worked out at the edge that accepts it.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_flags.push_back(track_button(offered_poll));
         end
         if (!req_tvalid || req_tready) begin
            if (poll_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered_poll = poll_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {7'd0, offered_poll};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor. Every accepted beat is matched against the oldest
   // prediction; the ready for the next edge is chosen here as well.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_flags.size() == 0) begin
               $error("result beat %02h arrived with no poll outstanding", rsp_tdata);
               fail_count++;
            end else begin
               bdch_pkg::result_type want;
               want = expected_flags.pop_front();
               check_flag("pressed", want.pressed, rsp_tdata[0]);
               check_flag("clicked_edge", want.clicked_edge, rsp_tdata[1]);
               check_flag("double_clicked", want.double_clicked, rsp_tdata[2]);
               check_flag("held", want.held, rsp_tdata[3]);
               check_flag("held_edge", want.held_edge, rsp_tdata[4]);
            end
         end
         rsp_tready <= hold_off_left == 0 && $urandom_range(99) >= receiver_stall_pct;
      end
   end

   // Counts down the long hold-off of the receiver once it is requested.
   always @(posedge clock) begin
      if (hold_off_request && hold_off_left == 0) begin
         hold_off_request = 1'b0;
         hold_off_left <= HOLD_OFF_CYCLES;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
      end
   end

   // Watchdog: a run that hangs ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic queue_poll(input logic pin, input logic [TIME_BITS-1:0] now);
      stamp_ms = now;
      poll_queue.push_back('{now_ms: now, pin_level: pin});
      polls_queued++;
   endtask

   task automatic push_poll(input logic pin, input logic [TIME_BITS-1:0] step);
      queue_poll(pin, stamp_ms + step);
   endtask

   // One press: a low poll, high polls for at least len_ms, and a release.
   // Now and then the pin drops for one poll in the middle, as a bounce would.
   task automatic push_press(input int unsigned len_ms);
      int unsigned step_max;
      int unsigned elapsed;
      int unsigned step;
      step_max = len_ms / 6 + 1;
      elapsed  = 0;
      push_poll(1'b0, $urandom_range(1, step_max));
      do begin
         step = $urandom_range(1, step_max);
         elapsed += step;
         push_poll(1'b1, step);
         if ($urandom_range(15) == 0) push_poll(1'b0, 0);
      end while (elapsed <= len_ms);
      push_poll(1'b0, $urandom_range(1, step_max));
   endtask

   // Random polls, mostly whole presses scaled to the current timing, with
   // bounces, repeated stamps, wild jumps and time running backwards mixed in.
   task automatic fill_random(input int unsigned count);
      int unsigned target;
      int unsigned deb;
      int unsigned gap;
      int unsigned hold;
      target = polls_queued + count;
      deb    = 32'(timing_cfg.debounce_ms);
      gap    = 32'(timing_cfg.double_gap_ms);
      hold   = 32'(timing_cfg.hold_ms);
      if ($urandom_range(3) == 0) stamp_ms = 32'hFFFF_FFFF - $urandom_range(2 * hold + 2);
      while (polls_queued < target) begin
         case ($urandom_range(9))
            0, 1, 2: push_press($urandom_range(2 * deb + 2));
            3, 4: push_press(hold + deb - hold / 8 + $urandom_range(hold / 4 + 2));
            5, 6: begin
               // Two short presses with a release in between of about the gap.
               push_press(deb + $urandom_range(3));
               push_poll(1'b0, $urandom_range(2 * gap + 2));
               push_press(deb + $urandom_range(3));
            end
            7: repeat ($urandom_range(3, 8)) push_poll(1'($urandom_range(1)),
                                                       $urandom_range(3));
            8: begin
               if ($urandom_range(1)) push_poll(1'($urandom_range(1)), $urandom());
               else push_poll(1'($urandom_range(1)), 32'd0 - $urandom_range(1, 2 * deb + 2));
            end
            default: repeat ($urandom_range(3, 6)) push_poll(1'b1, 0);
         endcase
      end
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [14:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         bdch_pkg::CSR_DEBOUNCE:   timing_cfg.debounce_ms   = value;
         bdch_pkg::CSR_DOUBLE_GAP: timing_cfg.double_gap_ms = value;
         bdch_pkg::CSR_HOLD:       timing_cfg.hold_ms       = value;
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [14:0] deb, input logic [14:0] gap,
                             input logic [14:0] hold);
      write_csr(bdch_pkg::CSR_DEBOUNCE, deb);
      write_csr(bdch_pkg::CSR_DOUBLE_GAP, gap);
      write_csr(bdch_pkg::CSR_HOLD, hold);
   endtask

   // Waits until every poll is taken and every result checked, then a little
   // longer so the block is surely idle before the next register write.
   task automatic drain();
      do @(posedge clock);
      while (poll_queue.size() != 0 || req_tvalid || expected_flags.size() != 0 ||
             results_seen < polls_queued);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                            input int unsigned count);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      fill_random(count);
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed polls at the reset timing of 20, 500 and 1000 ms: the press
      // threshold on both sides, a hold and its edge, a click whose partner
      // comes too late, a true double click, a press across the time wrap,
      // time running backwards, and click and hold rising on one poll.
      queue_poll(1'b0, 32'd0);
      queue_poll(1'b1, 32'd0);
      queue_poll(1'b1, 32'd19);
      queue_poll(1'b1, 32'd20);
      queue_poll(1'b1, 32'd1020);
      queue_poll(1'b1, 32'd1021);
      queue_poll(1'b0, 32'd1022);
      queue_poll(1'b1, 32'd1030);
      queue_poll(1'b1, 32'd1050);
      queue_poll(1'b0, 32'd1060);
      queue_poll(1'b1, 32'd1070);
      queue_poll(1'b1, 32'd1080);
      queue_poll(1'b0, 32'hFFFF_FFFF);
      queue_poll(1'b1, 32'h0000_0013);
      queue_poll(1'b1, 32'h0000_0005);
      queue_poll(1'b1, 32'h7FFF_FFFF);
      queue_poll(1'b0, 32'hFFFF_FFFF);
      queue_poll(1'b1, 32'hAAAA_AAAA);
      queue_poll(1'b1, 32'h5555_5555);
      queue_poll(1'b0, 32'h5555_5556);
      drain();

      // Reset timing, both sides running flat out.
      run_phase(0, 0, 300);

      // Everything at zero: pressed on the first high poll, gap open only at the same stamp.
      set_timing(15'd0, 15'd0, 15'd0);
      run_phase(58, 0, 320);

      // Everything at the top of its range.
      set_timing(15'h7FFF, 15'h7FFF, 15'h7FFF);
      run_phase(0, 58, 320);

      // Short random timing, both sides idling, and one long receiver
      // hold-off so the block backs up and stalls the poll channel.
      set_timing(15'($urandom_range(50)), 15'($urandom_range(300)),
                 15'($urandom_range(600)));
      hold_off_request = 1'b1;
      run_phase(34, 34, 320);

      // Random timing anywhere in range, plus a write to the unused index
      // that must leave the timing as it was.
      set_timing(15'($urandom_range(15'h7FFF)), 15'($urandom_range(15'h7FFF)),
                 15'($urandom_range(15'h7FFF)));
      write_csr(CSR_SPARE, 15'($urandom_range(15'h7FFF)));
      run_phase(0, 0, 320);

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
`default_nettype wire
